// File: rtl/hsvrgb_pkg.sv
// ----------------------------------------------------------------------------
// hsvrgb_pkg
// Shared types and constants for the HSV to RGB converter.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

  localparam int unsigned MAX_PIXELS = 1024;

  localparam int unsigned IDX_IN_W  = 12;
  localparam int unsigned IDX_OUT_W = 10;
  localparam int unsigned HUE_IN_W  = 10;
  localparam int unsigned HUE_W     = 9;
  localparam int unsigned CH_W      = 8;
  localparam int unsigned LEN_W     = 11;
  localparam int unsigned FRAC_W    = 6;
  localparam int unsigned SEC_W     = 3;

  localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

  // Hue sectors, 60 degrees each
  localparam logic [SEC_W-1:0] SEC_RED     = 3'd0;
  localparam logic [SEC_W-1:0] SEC_YELLOW  = 3'd1;
  localparam logic [SEC_W-1:0] SEC_GREEN   = 3'd2;
  localparam logic [SEC_W-1:0] SEC_CYAN    = 3'd3;
  localparam logic [SEC_W-1:0] SEC_BLUE    = 3'd4;
  localparam logic [SEC_W-1:0] SEC_MAGENTA = 3'd5;

  localparam logic [FRAC_W-1:0] SECTOR_SPAN = 6'd60;

  // floor(x/60) = (x * RECIP_60) >> RECIP_SHIFT for x < 2^20/44
  localparam int unsigned       RECIP_W     = 15;
  localparam int unsigned       RECIP_SHIFT = 20;
  localparam logic [RECIP_W-1:0] RECIP_60   = 15'd17477;

  localparam int unsigned RPROD_W = CH_W + FRAC_W;
  localparam int unsigned QPROD_W = RPROD_W + RECIP_W;

  typedef struct packed {
    logic [SEC_W-1:0]  sector;
    logic [FRAC_W-1:0] frac;
  } sector_t;

endpackage

// File: rtl/hsvrgb_if.sv
// ----------------------------------------------------------------------------
// hsvrgb_if
// Valid/ready channels of the HSV to RGB converter.
// ----------------------------------------------------------------------------
interface hsvrgb_hsv_if;
  logic                                valid;
  logic                                ready;
  logic [hsvrgb_pkg::IDX_IN_W-1:0]     pixel_index;
  logic [hsvrgb_pkg::HUE_IN_W-1:0]     hue_degrees;
  logic [hsvrgb_pkg::CH_W-1:0]         saturation;
  logic [hsvrgb_pkg::CH_W-1:0]         brightness;

  modport source (output valid, pixel_index, hue_degrees, saturation, brightness,
                  input ready);
  modport sink   (input valid, pixel_index, hue_degrees, saturation, brightness,
                  output ready);
endinterface

interface hsvrgb_rgb_if;
  logic                                valid;
  logic                                ready;
  logic [hsvrgb_pkg::IDX_OUT_W-1:0]    clamped_index;
  logic [hsvrgb_pkg::CH_W-1:0]         red;
  logic [hsvrgb_pkg::CH_W-1:0]         green;
  logic [hsvrgb_pkg::CH_W-1:0]         blue;

  modport source (output valid, clamped_index, red, green, blue, input ready);
  modport sink   (input valid, clamped_index, red, green, blue, output ready);
endinterface

interface hsvrgb_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [hsvrgb_pkg::LEN_W-1:0]        data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// File: rtl/hsv_to_rgb_converter_core.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_core
// Five-stage pipelined HSV to RGB conversion with strip index clamping.
// ----------------------------------------------------------------------------
//  channel    | modport | carries
//  pixel_in   | sink    | pixel_index, hue_degrees, saturation, brightness
//  pixel_out  | source  | clamped_index, red, green, blue
//  cfg        | sink    | strip_length write data
//
//  One pixel per cycle sustained while pixel_out is ready.
//  Stages: index clamp + hue reduce + base multiply, sector split, span*frac multiply,
//  reciprocal multiply for /60, channel select into the output register.
//  Each stage holds its own valid bit and loads when it is empty or moves on,
//  so bubbles close up under a stalled output. cfg is always ready.
//  rst (synchronous) clears valid bits and sets strip_length to 1024.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_core (
  input  logic                clk,
  input  logic                rst,
  hsvrgb_hsv_if.sink          pixel_in,
  hsvrgb_rgb_if.source        pixel_out,
  hsvrgb_cfg_if.sink          cfg
);

  localparam int unsigned CH  = hsvrgb_pkg::CH_W;
  localparam int unsigned IDX = hsvrgb_pkg::IDX_OUT_W;

  logic [hsvrgb_pkg::LEN_W-1:0] strip_length;

  // stage enables
  logic en1, en2, en3, en4, en5;
  logic v1, v2, v3, v4, vout;

  // stage 1
  logic [IDX-1:0]                  idx1;
  logic [hsvrgb_pkg::HUE_W-1:0]    hue1;
  logic                            gray1;
  logic [CH-1:0]                   val1;
  logic [2*CH-1:0]                 prod1;
  // stage 2
  logic [IDX-1:0]                  idx2;
  logic                            gray2;
  logic [CH-1:0]                   val2, base2, span2;
  hsvrgb_pkg::sector_t             sect2;
  // stage 3
  logic [IDX-1:0]                  idx3;
  logic                            gray3;
  logic [CH-1:0]                   val3, base3;
  logic [hsvrgb_pkg::SEC_W-1:0]    sec3;
  logic [hsvrgb_pkg::RPROD_W-1:0]  rprod3;
  // stage 4
  logic [IDX-1:0]                  idx4;
  logic                            gray4;
  logic [CH-1:0]                   val4, base4;
  logic [hsvrgb_pkg::SEC_W-1:0]    sec4;
  logic [hsvrgb_pkg::QPROD_W-1:0]  qprod4;

  // comb
  logic [hsvrgb_pkg::LEN_W-1:0]    len_lim;
  logic [hsvrgb_pkg::LEN_W-1:0]    last_idx;
  logic [IDX-1:0]                  idx_next;
  logic [hsvrgb_pkg::HUE_IN_W-1:0] hue_red;
  logic [CH-1:0]                   inv_sat;
  hsvrgb_pkg::sector_t             sect_next;
  logic [CH:0]                     ramp_sum;
  logic [CH-1:0]                   ramp;
  logic [CH-1:0]                   red_next, green_next, blue_next;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      strip_length <= hsvrgb_pkg::LEN_RESET;
    end else if (cfg.valid) begin
      strip_length <= cfg.data;
    end
  end

  // handshake chain
  assign en5 = !vout || pixel_out.ready;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign pixel_in.ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      vout <= 1'b0;
    end else begin
      if (en1) v1   <= pixel_in.valid;
      if (en2) v2   <= v1;
      if (en3) v3   <= v2;
      if (en4) v4   <= v3;
      if (en5) vout <= v4;
    end
  end

  // stage 1: clamp, hue mod 360, base product
  always_comb begin
    if (strip_length == '0) begin
      len_lim = hsvrgb_pkg::LEN_W'(1);
    end else if (32'(strip_length) > hsvrgb_pkg::MAX_PIXELS) begin
      len_lim = hsvrgb_pkg::LEN_W'(hsvrgb_pkg::MAX_PIXELS);
    end else begin
      len_lim = strip_length;
    end
    last_idx = len_lim - hsvrgb_pkg::LEN_W'(1);
    if (pixel_in.pixel_index > {1'b0, last_idx}) begin
      idx_next = last_idx[IDX-1:0];
    end else begin
      idx_next = pixel_in.pixel_index[IDX-1:0];
    end
    if (pixel_in.hue_degrees >= 10'd720) begin
      hue_red = pixel_in.hue_degrees - 10'd720;
    end else if (pixel_in.hue_degrees >= 10'd360) begin
      hue_red = pixel_in.hue_degrees - 10'd360;
    end else begin
      hue_red = pixel_in.hue_degrees;
    end
    inv_sat = 8'd255 - pixel_in.saturation;
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      idx1  <= idx_next;
      hue1  <= hue_red[hsvrgb_pkg::HUE_W-1:0];
      gray1 <= (pixel_in.saturation == '0);
      val1  <= pixel_in.brightness;
      prod1 <= (2*CH)'(inv_sat) * (2*CH)'(pixel_in.brightness);
    end
  end

  // stage 2: sector split, base and span
  hsvrgb_sector u_sector (
    .hue  (hue1),
    .sect (sect_next)
  );

  always_ff @(posedge clk) begin
    if (en2) begin
      idx2  <= idx1;
      gray2 <= gray1;
      val2  <= val1;
      base2 <= prod1[2*CH-1:CH];
      span2 <= val1 - prod1[2*CH-1:CH];
      sect2 <= sect_next;
    end
  end

  // stage 3: span * frac
  always_ff @(posedge clk) begin
    if (en3) begin
      idx3   <= idx2;
      gray3  <= gray2;
      val3   <= val2;
      base3  <= base2;
      sec3   <= sect2.sector;
      rprod3 <= hsvrgb_pkg::RPROD_W'(span2) * hsvrgb_pkg::RPROD_W'(sect2.frac);
    end
  end

  // stage 4: divide by 60 through reciprocal
  always_ff @(posedge clk) begin
    if (en4) begin
      idx4   <= idx3;
      gray4  <= gray3;
      val4   <= val3;
      base4  <= base3;
      sec4   <= sec3;
      qprod4 <= hsvrgb_pkg::QPROD_W'(rprod3) * hsvrgb_pkg::QPROD_W'(hsvrgb_pkg::RECIP_60);
    end
  end

  // stage 5: channel select
  assign ramp_sum = {1'b0, qprod4[hsvrgb_pkg::RECIP_SHIFT +: CH]} + {1'b0, base4};
  assign ramp     = ramp_sum[CH-1:0];

  always_comb begin
    if (gray4) begin
      red_next   = val4;
      green_next = val4;
      blue_next  = val4;
    end else begin
      case (sec4)
        hsvrgb_pkg::SEC_RED: begin
          red_next = val4;  green_next = ramp;  blue_next = base4;
        end
        hsvrgb_pkg::SEC_YELLOW: begin
          red_next = ramp;  green_next = val4;  blue_next = base4;
        end
        hsvrgb_pkg::SEC_GREEN: begin
          red_next = base4; green_next = val4;  blue_next = ramp;
        end
        hsvrgb_pkg::SEC_CYAN: begin
          red_next = base4; green_next = ramp;  blue_next = val4;
        end
        hsvrgb_pkg::SEC_BLUE: begin
          red_next = ramp;  green_next = base4; blue_next = val4;
        end
        default: begin
          red_next = val4;  green_next = base4; blue_next = ramp;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      pixel_out.clamped_index <= idx4;
      pixel_out.red           <= red_next;
      pixel_out.green         <= green_next;
      pixel_out.blue          <= blue_next;
    end
  end

  assign pixel_out.valid = vout;

`ifndef ASSERT_OFF
  a_span_split: assert property (@(posedge clk) disable iff (rst)
    v2 |-> ({1'b0, base2} + {1'b0, span2}) == {1'b0, val2})
    else $error("base plus span differs from brightness");

  a_frac_range: assert property (@(posedge clk) disable iff (rst)
    v2 |-> sect2.frac <= hsvrgb_pkg::SECTOR_SPAN)
    else $error("ramp fraction beyond one sector");

  a_ramp_bound: assert property (@(posedge clk) disable iff (rst)
    (v4 && !gray4) |-> (ramp_sum <= {1'b0, val4}))
    else $error("ramp level above brightness");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    (v4 && en5) |=> pixel_out.valid)
    else $error("stage 4 transaction lost");
`endif

endmodule

// File: rtl/hsvrgb_sector.sv
// ----------------------------------------------------------------------------
// hsvrgb_sector
// Splits a reduced hue (0..359) into its sector and ramp position.
// ----------------------------------------------------------------------------
module hsvrgb_sector (
  input  logic [hsvrgb_pkg::HUE_W-1:0] hue,
  output hsvrgb_pkg::sector_t          sect
);

  logic [hsvrgb_pkg::SEC_W-1:0]  sector;
  logic [hsvrgb_pkg::HUE_W-1:0]  start;
  logic [hsvrgb_pkg::FRAC_W-1:0] up;

  always_comb begin
    if (hue >= 9'd300) begin
      sector = hsvrgb_pkg::SEC_MAGENTA;
      start  = 9'd300;
    end else if (hue >= 9'd240) begin
      sector = hsvrgb_pkg::SEC_BLUE;
      start  = 9'd240;
    end else if (hue >= 9'd180) begin
      sector = hsvrgb_pkg::SEC_CYAN;
      start  = 9'd180;
    end else if (hue >= 9'd120) begin
      sector = hsvrgb_pkg::SEC_GREEN;
      start  = 9'd120;
    end else if (hue >= 9'd60) begin
      sector = hsvrgb_pkg::SEC_YELLOW;
      start  = 9'd60;
    end else begin
      sector = hsvrgb_pkg::SEC_RED;
      start  = 9'd0;
    end
  end

  assign up = hsvrgb_pkg::FRAC_W'(hue - start);

  // odd sectors ramp downward
  always_comb begin
    sect.sector = sector;
    if (sector[0]) begin
      sect.frac = hsvrgb_pkg::SECTOR_SPAN - up;
    end else begin
      sect.frac = up;
    end
  end

endmodule

// File: verif/hsv_to_rgb_converter_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_core_tb
// Self-checking bench for the HSV to RGB converter core. Sends pixel
// transactions with random gaps, stalls the output side at random, and checks
// every result transaction field by field against an in-bench predictor that
// covers gray, the six hue sectors, hue wrap and strip index clamping across
// several strip length settings.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_core_tb;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned PIPE_LATENCY = 5;

  typedef struct packed {
    logic [hsvrgb_pkg::IDX_IN_W-1:0] pos;
    logic [hsvrgb_pkg::HUE_IN_W-1:0] hue;
    logic [hsvrgb_pkg::CH_W-1:0]     sat;
    logic [hsvrgb_pkg::CH_W-1:0]     val;
  } hsv_pixel_t;

  typedef struct packed {
    logic [hsvrgb_pkg::IDX_OUT_W-1:0] pos;
    logic [hsvrgb_pkg::CH_W-1:0]      red;
    logic [hsvrgb_pkg::CH_W-1:0]      green;
    logic [hsvrgb_pkg::CH_W-1:0]      blue;
  } rgb_pixel_t;

  logic clk;
  logic rst;

  hsvrgb_hsv_if pixel_in_if ();
  hsvrgb_rgb_if pixel_out_if ();
  hsvrgb_cfg_if cfg_if ();

  hsv_to_rgb_converter_core dut (
    .clk       (clk),
    .rst       (rst),
    .pixel_in  (pixel_in_if.sink),
    .pixel_out (pixel_out_if.source),
    .cfg       (cfg_if.sink)
  );

  logic [hsvrgb_pkg::LEN_W-1:0] strip_len = hsvrgb_pkg::LEN_RESET;
  rgb_pixel_t       expected_pixels [$];
  rgb_pixel_t       expected_px;
  int unsigned      pixels_sent     = 0;
  int unsigned      pixels_checked  = 0;
  int unsigned      length_writes   = 0;
  int unsigned      err_count       = 0;
  int unsigned      cycle_count     = 0;
  int unsigned      src_gap_pct     = 20;
  int unsigned      sink_stall_pct  = 20;
  int unsigned      hold_left       = 0;
  int unsigned      stall_left      = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    pixel_in_if.valid       = 1'b0;
    pixel_in_if.pixel_index = '0;
    pixel_in_if.hue_degrees = '0;
    pixel_in_if.saturation  = '0;
    pixel_in_if.brightness  = '0;
    cfg_if.valid            = 1'b0;
    cfg_if.data             = '0;
  end

  function automatic rgb_pixel_t hsv_predict(hsv_pixel_t px);
    rgb_pixel_t       res;
    int unsigned      len, pos, hue, sat, val, base, span, up, rise, fall, r, g, b;
    logic [hsvrgb_pkg::SEC_W-1:0] sector;
    len = 32'(strip_len);
    if (len == 0) len = 1;
    if (len > hsvrgb_pkg::MAX_PIXELS) len = hsvrgb_pkg::MAX_PIXELS;
    pos = 32'(px.pos);
    if (pos > len - 1) pos = len - 1;
    hue = 32'(px.hue) % 360;
    sat = 32'(px.sat);
    val = 32'(px.val);
    if (sat == 0) begin
      r = val;
      g = val;
      b = val;
    end else begin
      base = ((255 - sat) * val) >> 8;
      span = val - base;
      up   = hue % 32'(hsvrgb_pkg::SECTOR_SPAN);
      rise = (span * up) / 32'(hsvrgb_pkg::SECTOR_SPAN) + base;
      fall = (span * (32'(hsvrgb_pkg::SECTOR_SPAN) - up)) / 32'(hsvrgb_pkg::SECTOR_SPAN)
             + base;
      sector = hsvrgb_pkg::SEC_W'(hue / 32'(hsvrgb_pkg::SECTOR_SPAN));
      case (sector)
        hsvrgb_pkg::SEC_RED: begin
          r = val;  g = rise; b = base;
        end
        hsvrgb_pkg::SEC_YELLOW: begin
          r = fall; g = val;  b = base;
        end
        hsvrgb_pkg::SEC_GREEN: begin
          r = base; g = val;  b = rise;
        end
        hsvrgb_pkg::SEC_CYAN: begin
          r = base; g = fall; b = val;
        end
        hsvrgb_pkg::SEC_BLUE: begin
          r = rise; g = base; b = val;
        end
        default: begin
          r = val;  g = base; b = fall;
        end
      endcase
    end
    res.pos   = pos[hsvrgb_pkg::IDX_OUT_W-1:0];
    res.red   = r[hsvrgb_pkg::CH_W-1:0];
    res.green = g[hsvrgb_pkg::CH_W-1:0];
    res.blue  = b[hsvrgb_pkg::CH_W-1:0];
    return res;
  endfunction

  function automatic hsv_pixel_t make_pixel(int unsigned pos, int unsigned hue,
                                            int unsigned sat, int unsigned val);
    hsv_pixel_t p;
    p.pos = hsvrgb_pkg::IDX_IN_W'(pos);
    p.hue = hsvrgb_pkg::HUE_IN_W'(hue);
    p.sat = hsvrgb_pkg::CH_W'(sat);
    p.val = hsvrgb_pkg::CH_W'(val);
    return p;
  endfunction

  // index choice biased toward the clamp boundary of the current strip
  function automatic logic [hsvrgb_pkg::IDX_IN_W-1:0] pick_pos();
    int unsigned eff;
    eff = (strip_len == 0) ? 1 :
          ((strip_len > hsvrgb_pkg::MAX_PIXELS) ? hsvrgb_pkg::MAX_PIXELS : 32'(strip_len));
    case ($urandom_range(0, 5))
      0:       return hsvrgb_pkg::IDX_IN_W'(eff - 1);
      1:       return hsvrgb_pkg::IDX_IN_W'(eff);
      2:       return '0;
      3:       return '1;
      4:       return hsvrgb_pkg::IDX_IN_W'($urandom_range(0, eff + 2));
      default: return hsvrgb_pkg::IDX_IN_W'($urandom());
    endcase
  endfunction

  function automatic hsv_pixel_t random_pixel();
    hsv_pixel_t p;
    p.pos = pick_pos();
    case ($urandom_range(0, 7))
      0:       p.hue = hsvrgb_pkg::HUE_IN_W'(60 * $urandom_range(0, 17));
      1:       p.hue = hsvrgb_pkg::HUE_IN_W'(1023 - $urandom_range(0, 63));
      default: p.hue = hsvrgb_pkg::HUE_IN_W'($urandom());
    endcase
    case ($urandom_range(0, 9))
      0:       p.sat = '0;
      1:       p.sat = '1;
      2:       p.sat = 8'd1;
      default: p.sat = hsvrgb_pkg::CH_W'($urandom());
    endcase
    case ($urandom_range(0, 9))
      0:       p.val = '0;
      1:       p.val = '1;
      default: p.val = hsvrgb_pkg::CH_W'($urandom());
    endcase
    return p;
  endfunction

  // all driving tasks start and end at a falling edge
  task automatic send_pixel(hsv_pixel_t px);
    pixel_in_if.valid       = 1'b1;
    pixel_in_if.pixel_index = px.pos;
    pixel_in_if.hue_degrees = px.hue;
    pixel_in_if.saturation  = px.sat;
    pixel_in_if.brightness  = px.val;
    do @(posedge clk); while (!pixel_in_if.ready);
    expected_pixels.push_back(hsv_predict(px));
    pixels_sent++;
    @(negedge clk);
  endtask

  task automatic idle_source(int unsigned n);
    pixel_in_if.valid = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic maybe_gap();
    if ($urandom_range(0, 99) < src_gap_pct) idle_source($urandom_range(1, 12));
  endtask

  task automatic send_random_pixels(int unsigned n);
    repeat (n) begin
      send_pixel(random_pixel());
      maybe_gap();
    end
  endtask

  task automatic wait_drained();
    pixel_in_if.valid = 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk);
  endtask

  task automatic write_strip_length(logic [hsvrgb_pkg::LEN_W-1:0] len);
    wait_drained();
    cfg_if.data  = len;
    cfg_if.valid = 1'b1;
    do @(posedge clk); while (!cfg_if.ready);
    strip_len = len;
    length_writes++;
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  task automatic test_gray_and_extremes();
    send_pixel(make_pixel(0, 0, 0, 0));
    send_pixel(make_pixel(4095, 1023, 0, 255));
    send_pixel(make_pixel(17, 500, 0, 77));
    send_pixel(make_pixel(4095, 1023, 255, 255));
    maybe_gap();
    send_pixel(make_pixel(0, 0, 1, 255));
    send_pixel(make_pixel(5, 45, 128, 1));
    wait_drained();
  endtask

  task automatic test_sector_edges();
    int unsigned edges [12] = '{0, 59, 60, 119, 120, 179, 180, 239, 240, 299, 300, 359};
    foreach (edges[i]) begin
      if (i % 2 == 0) send_pixel(make_pixel(i, edges[i], 255, 255));
      else send_pixel(make_pixel(i, edges[i], 200, 131));
      maybe_gap();
    end
    wait_drained();
  endtask

  task automatic test_hue_wrap_and_clamp();
    send_pixel(make_pixel(1023, 360, 255, 255));
    send_pixel(make_pixel(1024, 719, 180, 240));
    send_pixel(make_pixel(2048, 720, 90, 200));
    wait_drained();
  endtask

  task automatic test_strip_lengths();
    logic [hsvrgb_pkg::LEN_W-1:0] lengths [7];
    lengths = '{11'd1, 11'd0, 11'd2047, 11'd1025, hsvrgb_pkg::LEN_RESET, 11'd600, 11'd0};
    lengths[6] = hsvrgb_pkg::LEN_W'($urandom_range(2, 1023));
    foreach (lengths[i]) begin
      write_strip_length(lengths[i]);
      send_random_pixels(40);
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    write_strip_length(hsvrgb_pkg::LEN_RESET);
    src_gap_pct = 0;
    hold_left   = 120;
    repeat (40) send_pixel(random_pixel());
    wait_drained();
    src_gap_pct = 20;
  endtask

  task automatic test_random_traffic();
    int unsigned densities [3] = '{0, 10, 40};
    for (int unsigned blk = 0; blk < 12; blk++) begin
      if (blk % 3 == 0) begin
        if ($urandom_range(0, 4) == 0) write_strip_length('0);
        else write_strip_length(hsvrgb_pkg::LEN_W'($urandom_range(1, 2047)));
      end
      src_gap_pct    = densities[$urandom_range(0, 2)];
      sink_stall_pct = densities[$urandom_range(0, 2)];
      send_random_pixels(100);
    end
    wait_drained();
  endtask

  task automatic test_full_rate();
    src_gap_pct    = 0;
    sink_stall_pct = 0;
    write_strip_length(hsvrgb_pkg::LEN_W'($urandom_range(1, 1024)));
    repeat (150) send_pixel(random_pixel());
    wait_drained();
  endtask

  // output ready: random stall bursts plus a long hold-off on request
  initial begin
    pixel_out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        pixel_out_if.ready = 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        pixel_out_if.ready = 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 99) < sink_stall_pct) begin
        pixel_out_if.ready = 1'b0;
        stall_left = $urandom_range(1, 12) - 1;
      end else begin
        pixel_out_if.ready = 1'b1;
      end
    end
  end

  task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && pixel_out_if.valid && pixel_out_if.ready) begin
      if (expected_pixels.size() == 0) begin
        $error("result transaction with no pixel pending: index %0d rgb %0d/%0d/%0d",
               pixel_out_if.clamped_index, pixel_out_if.red, pixel_out_if.green,
               pixel_out_if.blue);
        err_count++;
      end else begin
        expected_px = expected_pixels.pop_front();
        check_field("clamped_index", 16'(expected_px.pos),
                    16'(pixel_out_if.clamped_index));
        check_field("red", 16'(expected_px.red), 16'(pixel_out_if.red));
        check_field("green", 16'(expected_px.green), 16'(pixel_out_if.green));
        check_field("blue", 16'(expected_px.blue), 16'(pixel_out_if.blue));
        pixels_checked++;
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles, %0d pixels pending", cycle_count,
             expected_pixels.size());
    $display("FAIL");
    $finish;
  end

  initial begin
    rst = 1'b1;
    repeat (2) @(negedge clk);
    rst = 1'b0;
    test_gray_and_extremes();
    test_sector_edges();
    test_hue_wrap_and_clamp();
    test_strip_lengths();
    test_backpressure();
    test_random_traffic();
    test_full_rate();
    wait_drained();
    repeat (PIPE_LATENCY * 4) @(negedge clk);
    $display("Converted %0d pixels, checked %0d results over %0d strip length writes",
             pixels_sent, pixels_checked, length_writes);
    $display("Covered gray, all hue sectors and wrap, index clamp, stalls and full rate");
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
